// ----- src/quaternion_normal_tangent_projection_core_assert.svh -----
// Assertion macros shared by the checkers of the tangent projection core.
// Depends on nothing; included by qntp_checker.sv.
`ifndef QUATERNION_NORMAL_TANGENT_PROJECTION_CORE_ASSERT_SVH
`define QUATERNION_NORMAL_TANGENT_PROJECTION_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define QNTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define QNTP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/qntp_pkg.sv -----
// Package of the tangent projection core: field widths, pipeline geometry and payload types.
// Depends on nothing; used by the interfaces, the divider, the top level and the checker.
package qntp_pkg;

    // Transaction fields
    localparam int QUAT_W  = 16;
    localparam int FORCE_W = 32;
    localparam int PROJ_W  = 32;
    localparam int LANES   = 3;

    // Q2.30 normal and rounding position
    localparam int FRAC_SH = 30;

    // Internal widths
    localparam int PROD_Q_W = 2 * QUAT_W;       // quaternion component products
    localparam int NUM_W    = PROD_Q_W + 2;     // signed numerators and squared norm
    localparam int MAG_W    = NUM_W - 1;        // numerator magnitude, up to 2^32
    localparam int QUO_W    = 32;               // quotient with one extra rounding bit
    localparam int REM_W    = MAG_W - 1;        // partial remainder, always below divisor
    localparam int NRM_W    = QUO_W;            // signed Q2.30 normal component
    localparam int PROD1_W  = NRM_W + FORCE_W;  // normal times force
    localparam int SUM_W    = PROD1_W + 2;      // dot product sum and second product
    localparam int DOT_W    = 34;               // dot product in Q16.16
    localparam int CORR_W   = 34;               // correction in Q16.16
    localparam int SUB_W    = CORR_W + 1;       // force minus correction

    // Pipeline geometry
    localparam int DIV_STAGES  = QUO_W;
    localparam int PRE_STAGES  = 3;
    localparam int POST_STAGES = 7;
    localparam int NUM_STAGES  = PRE_STAGES + DIV_STAGES + POST_STAGES;

    typedef logic [LANES-1:0][FORCE_W-1:0] t_vec;
    typedef logic [LANES-1:0][PROJ_W-1:0]  t_proj;

endpackage

// ----- src/qntp_intf.sv -----
// Handshake channels of the tangent projection core: request and response interfaces.
// Depends on qntp_pkg for the field widths.
interface qntp_in_if;
    import qntp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, force_x, force_y, force_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, force_x, force_y, force_z,
        output ready
    );
endinterface

interface qntp_out_if;
    import qntp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PROJ_W-1:0] proj_x;
    logic signed [PROJ_W-1:0] proj_y;
    logic signed [PROJ_W-1:0] proj_z;

    modport source (
        output valid, proj_x, proj_y, proj_z,
        input  ready
    );
    modport sink (
        input  valid, proj_x, proj_y, proj_z,
        output ready
    );
endinterface

// ----- src/quaternion_normal_tangent_projection_core.sv -----
// Tangent projection core: one response for every accepted request, in request order.
// One transaction per cycle while not held; the 32-stage normal divider sets the depth.
// The whole pipeline advances together and holds only while the skid register is occupied.
// Reset is synchronous, active low: it empties the pipeline and output registers, and
// request ready stays low until the first cycle after reset is released.
module quaternion_normal_tangent_projection_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qntp_in_if.sink    i_req,
    qntp_out_if.source o_rsp
);
    import qntp_pkg::*;

    // Round to nearest, ties away from zero, then drop the Q30 fraction
    function automatic logic signed [SUM_W-1:0] rnd_shift(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (v < 0) begin
            t = t - SUM_W'(1);
        end
        t = t + (SUM_W'(1) << (FRAC_SH - 1));
        return t >>> FRAC_SH;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic [PROJ_W-1:0] sat_proj(input logic signed [SUB_W-1:0] v);
        logic [PROJ_W-1:0] res;
        if ((&v[SUB_W-1:PROJ_W-1]) || !(|v[SUB_W-1:PROJ_W-1])) begin
            res = v[PROJ_W-1:0];
        end else if (v[SUB_W-1]) begin
            res = {1'b1, {(PROJ_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(PROJ_W-1){1'b1}}};
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Flow control: one shared advance for every stage. The skid register catches the single
    // transaction that can leave the pipeline in the cycle the output stalls.
    // ---------------------------------------------------------------------------------------
    logic                  r_run;
    logic [NUM_STAGES-1:0] r_vld;
    logic                  r_ob_vld;
    logic                  r_sk_vld;
    t_proj                 r_ob;
    t_proj                 r_sk;
    logic                  w_adv;
    logic                  w_push;
    logic                  w_pop;

    assign w_adv  = r_run && !r_sk_vld;
    assign w_push = w_adv && r_vld[NUM_STAGES-1];
    assign w_pop  = r_ob_vld && o_rsp.ready;

    assign i_req.ready  = w_adv;
    assign o_rsp.valid  = r_ob_vld;
    assign o_rsp.proj_x = r_ob[0];
    assign o_rsp.proj_y = r_ob[1];
    assign o_rsp.proj_z = r_ob[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
        end else begin
            r_run <= 1'b1;
            if (w_adv) begin
                r_vld <= {r_vld[NUM_STAGES-2:0], i_req.valid};
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage 1: component products
    // ---------------------------------------------------------------------------------------
    logic signed [PROD_Q_W-1:0] r_s1_ww, r_s1_xx, r_s1_yy, r_s1_zz;
    logic signed [PROD_Q_W-1:0] r_s1_xz, r_s1_wy, r_s1_yz, r_s1_wx;
    t_vec                       r_s1_f;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ww <= PROD_Q_W'(i_req.quat_w) * PROD_Q_W'(i_req.quat_w);
            r_s1_xx <= PROD_Q_W'(i_req.quat_x) * PROD_Q_W'(i_req.quat_x);
            r_s1_yy <= PROD_Q_W'(i_req.quat_y) * PROD_Q_W'(i_req.quat_y);
            r_s1_zz <= PROD_Q_W'(i_req.quat_z) * PROD_Q_W'(i_req.quat_z);
            r_s1_xz <= PROD_Q_W'(i_req.quat_x) * PROD_Q_W'(i_req.quat_z);
            r_s1_wy <= PROD_Q_W'(i_req.quat_w) * PROD_Q_W'(i_req.quat_y);
            r_s1_yz <= PROD_Q_W'(i_req.quat_y) * PROD_Q_W'(i_req.quat_z);
            r_s1_wx <= PROD_Q_W'(i_req.quat_w) * PROD_Q_W'(i_req.quat_x);
            r_s1_f  <= {i_req.force_z, i_req.force_y, i_req.force_x};
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage 2: squared norm and the three column numerators
    // ---------------------------------------------------------------------------------------
    logic signed [NUM_W-1:0] r_s2_nrm;
    logic signed [NUM_W-1:0] r_s2_a [LANES];
    t_vec                    r_s2_f;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_nrm  <= NUM_W'(r_s1_ww) + NUM_W'(r_s1_xx) + NUM_W'(r_s1_yy) + NUM_W'(r_s1_zz);
            r_s2_a[0] <= (NUM_W'(r_s1_xz) + NUM_W'(r_s1_wy)) <<< 1;
            r_s2_a[1] <= (NUM_W'(r_s1_yz) - NUM_W'(r_s1_wx)) <<< 1;
            r_s2_a[2] <= NUM_W'(r_s1_ww) - NUM_W'(r_s1_xx) - NUM_W'(r_s1_yy)
                         + NUM_W'(r_s1_zz);
            r_s2_f    <= r_s1_f;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage 3: split numerators into sign and magnitude, flag the zero quaternion
    // ---------------------------------------------------------------------------------------
    logic [MAG_W-1:0] r_s3_mag [LANES];
    logic [LANES-1:0] r_s3_neg;
    logic [MAG_W-1:0] r_s3_den;
    logic             r_s3_zero;
    t_vec             r_s3_f;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_s3_neg[i] <= r_s2_a[i][NUM_W-1];
                r_s3_mag[i] <= r_s2_a[i][NUM_W-1] ? MAG_W'(-r_s2_a[i]) : MAG_W'(r_s2_a[i]);
            end
            r_s3_den  <= r_s2_nrm[MAG_W-1:0];
            r_s3_zero <= (r_s2_nrm == '0);
            r_s3_f    <= r_s2_f;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Divider lanes: quotient magnitude * 2^31 / norm; sideband follows in a delay line
    // ---------------------------------------------------------------------------------------
    logic [QUO_W-1:0] w_quo [LANES];
    logic [LANES-1:0] r_dl_neg  [DIV_STAGES];
    logic             r_dl_zero [DIV_STAGES];
    t_vec             r_dl_f    [DIV_STAGES];

    for (genvar g = 0; g < LANES; g++) begin : g_div
        qntp_div u_div (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_num (r_s3_mag[g]),
            .i_den (r_s3_den),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl_neg[0]  <= r_s3_neg;
            r_dl_zero[0] <= r_s3_zero;
            r_dl_f[0]    <= r_s3_f;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dl_neg[k]  <= r_dl_neg[k-1];
                r_dl_zero[k] <= r_dl_zero[k-1];
                r_dl_f[k]    <= r_dl_f[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Normal stage: halve the extra quotient bit with rounding, restore sign, zero case
    // ---------------------------------------------------------------------------------------
    logic signed [NRM_W-1:0] n_rn_n [LANES];
    logic signed [NRM_W-1:0] r_rn_n [LANES];
    t_vec                    r_rn_f;

    always_comb begin
        logic [QUO_W:0]   v_rq;
        logic [NRM_W-1:0] v_mag;
        for (int i = 0; i < LANES; i++) begin
            v_rq      = {1'b0, w_quo[i]} + (QUO_W + 1)'(1);
            v_mag     = v_rq[QUO_W:1];
            n_rn_n[i] = r_dl_neg[DIV_STAGES-1][i] ? -v_mag : v_mag;
        end
        // Zero quaternion: take the unit z axis
        if (r_dl_zero[DIV_STAGES-1]) begin
            n_rn_n[0] = '0;
            n_rn_n[1] = '0;
            n_rn_n[2] = NRM_W'(1) << FRAC_SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rn_n <= n_rn_n;
            r_rn_f <= r_dl_f[DIV_STAGES-1];
        end
    end

    // ---------------------------------------------------------------------------------------
    // Dot product: products, sum, round to Q16.16
    // ---------------------------------------------------------------------------------------
    logic signed [PROD1_W-1:0] r_m1_p [LANES];
    logic signed [NRM_W-1:0]   r_m1_n [LANES];
    t_vec                      r_m1_f;
    logic signed [SUM_W-1:0]   r_sm_s;
    logic signed [NRM_W-1:0]   r_sm_n [LANES];
    t_vec                      r_sm_f;
    logic signed [DOT_W-1:0]   r_dt_d;
    logic signed [NRM_W-1:0]   r_dt_n [LANES];
    t_vec                      r_dt_f;
    logic signed [SUM_W-1:0]   w_dot_full;

    assign w_dot_full = rnd_shift(r_sm_s);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_m1_p[i] <= PROD1_W'(r_rn_n[i]) * PROD1_W'($signed(r_rn_f[i]));
            end
            r_m1_n <= r_rn_n;
            r_m1_f <= r_rn_f;

            r_sm_s <= SUM_W'(r_m1_p[0]) + SUM_W'(r_m1_p[1]) + SUM_W'(r_m1_p[2]);
            r_sm_n <= r_m1_n;
            r_sm_f <= r_m1_f;

            r_dt_d <= w_dot_full[DOT_W-1:0];
            r_dt_n <= r_sm_n;
            r_dt_f <= r_sm_f;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Correction n * d, rounded, then subtract from the force and saturate
    // ---------------------------------------------------------------------------------------
    logic signed [SUM_W-1:0]  r_m2_c [LANES];
    t_vec                     r_m2_f;
    logic signed [CORR_W-1:0] r_cr_c [LANES];
    t_vec                     r_cr_f;
    t_proj                    r_op_p;
    logic signed [SUM_W-1:0]  w_corr_full [LANES];
    t_proj                    n_op_p;

    always_comb begin
        logic signed [SUB_W-1:0] v_diff;
        for (int i = 0; i < LANES; i++) begin
            w_corr_full[i] = rnd_shift(r_m2_c[i]);
            v_diff         = SUB_W'($signed(r_cr_f[i])) - SUB_W'(r_cr_c[i]);
            n_op_p[i]      = sat_proj(v_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_m2_c[i] <= SUM_W'(r_dt_n[i]) * SUM_W'(r_dt_d);
                r_cr_c[i] <= w_corr_full[i][CORR_W-1:0];
            end
            r_m2_f <= r_dt_f;
            r_cr_f <= r_m2_f;
            r_op_p <= n_op_p;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Output register and skid register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_sk_vld) begin
                // Pipeline held this cycle: drain the skid entry
                r_ob     <= r_sk;
                r_sk_vld <= 1'b0;
            end else begin
                r_ob_vld <= w_push;
                r_ob     <= r_op_p;
            end
        end else if (!r_ob_vld) begin
            r_ob_vld <= w_push;
            r_ob     <= r_op_p;
        end else if (w_push) begin
            // Output stalled: park the arriving transaction
            r_sk_vld <= 1'b1;
            r_sk     <= r_op_p;
        end
    end

endmodule

// ----- src/qntp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, numerator not above divisor.
// Depends on qntp_pkg; instantiated once per lane by the top level.
module qntp_div (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [qntp_pkg::MAG_W-1:0] i_num,
    input  logic [qntp_pkg::MAG_W-1:0] i_den,
    output logic [qntp_pkg::QUO_W-1:0] o_quo
);
    import qntp_pkg::*;

    logic [REM_W-1:0] r_rem [DIV_STAGES];
    logic [MAG_W-1:0] r_den [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    logic             w_ge0;
    logic [MAG_W-1:0] w_diff0;

    // Integer bit: the numerator is at most the divisor, so it is 0 or 1
    always_comb begin
        w_ge0   = i_num >= i_den;
        w_diff0 = i_num - i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= w_ge0 ? w_diff0[REM_W-1:0] : i_num[REM_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= QUO_W'(w_ge0);
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
        logic [MAG_W-1:0] w_shift;
        logic [MAG_W-1:0] w_diff;
        logic             w_ge;

        always_comb begin
            w_shift = {r_rem[j-1], 1'b0};
            w_ge    = w_shift >= r_den[j-1];
            w_diff  = w_shift - r_den[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[j] <= w_ge ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
                r_den[j] <= r_den[j-1];
                r_quo[j] <= {r_quo[j-1][QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ----- src/qntp_checker.sv -----
// Port-level checker of the tangent projection core, bound to the top level.
// Depends on qntp_pkg and quaternion_normal_tangent_projection_core_assert.svh.
`include "quaternion_normal_tangent_projection_core_assert.svh"

module qntp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [qntp_pkg::PROJ_W-1:0] i_proj_x,
    input logic [qntp_pkg::PROJ_W-1:0] i_proj_y,
    input logic [qntp_pkg::PROJ_W-1:0] i_proj_z
);
    import qntp_pkg::*;

    localparam int INFLIGHT_MAX = NUM_STAGES + 2;
    localparam int CNT_W        = $clog2(INFLIGHT_MAX + 1);

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    // Track transactions accepted but not yet delivered
    always_comb begin
        n_inflight = r_inflight;
        if (i_in_valid && i_in_ready) begin
            n_inflight = n_inflight + CNT_W'(1);
        end
        if (i_out_valid && i_out_ready) begin
            n_inflight = n_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `QNTP_ASSERT(a_out_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "response valid dropped while stalled")
    `QNTP_ASSERT(a_out_data_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_proj_x) && $stable(i_proj_y) && $stable(i_proj_z), "response payload changed while stalled")
    `QNTP_ASSERT(a_no_phantom, i_clk, i_rst_n, i_out_valid |-> r_inflight != '0, "response without an outstanding request")
    `QNTP_ASSERT(a_capacity, i_clk, i_rst_n, r_inflight <= CNT_W'(INFLIGHT_MAX), "more transactions outstanding than storage")
    `QNTP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "response valid after reset")

endmodule

bind quaternion_normal_tangent_projection_core qntp_checker u_qntp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_proj_x    (o_rsp.proj_x),
    .i_proj_y    (o_rsp.proj_y),
    .i_proj_z    (o_rsp.proj_z)
);

// ----- dv/quaternion_normal_tangent_projection_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the quaternion tangent projection core: directed corners, backpressure,
// a gapless stream and a long random mix, each checked against an in-bench fixed-point predictor.
// Depends on qntp_pkg, the qntp_in_if / qntp_out_if interfaces and the core itself.
module quaternion_normal_tangent_projection_core_tb;
    import qntp_pkg::*;

    // Bench timing and limits
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 400;   // long response hold-off, well past the pipe depth
    localparam int DRAIN_CYCLES   = 60;    // wait after the drain for any stray response
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    // Fixed-point constants
    localparam longint Q30_UNIT = longint'(1) << FRAC_SH;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int     F_UNIT   = 65536;   // 1.0 in Q16.16
    localparam logic signed [QUAT_W-1:0]  Q_MAX = 16'sh7fff;
    localparam logic signed [QUAT_W-1:0]  Q_MIN = 16'sh8000;
    localparam logic signed [FORCE_W-1:0] F_MAX = 32'sh7fffffff;
    localparam logic signed [FORCE_W-1:0] F_MIN = 32'sh80000000;

    // One request transaction: orientation quaternion and force vector
    typedef struct {
        logic signed [QUAT_W-1:0]  w;
        logic signed [QUAT_W-1:0]  x;
        logic signed [QUAT_W-1:0]  y;
        logic signed [QUAT_W-1:0]  z;
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
    } t_quat_force;

    // One response transaction: the force with its normal component removed
    typedef struct {
        logic signed [PROJ_W-1:0] px;
        logic signed [PROJ_W-1:0] py;
        logic signed [PROJ_W-1:0] pz;
    } t_projection;

    logic i_clk;
    logic i_rst_n;

    qntp_in_if  req_if ();
    qntp_out_if rsp_if ();

    quaternion_normal_tangent_projection_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Projections predicted at request acceptance, oldest first
    t_projection pending_projections[$];

    int unsigned mismatch_count     = 0;
    int unsigned results_checked    = 0;
    int unsigned items_sent         = 0;
    int unsigned zero_quat_items    = 0;
    int unsigned saturated_lanes    = 0;
    int unsigned input_stall_cycles = 0;

    // Shared between the stimulus and the response-ready process
    bit steady_run   = 1'b0;   // no idling on either side while set
    bit hold_request = 1'b0;   // ask the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divide by a positive denominator, round to nearest with ties away from zero.
    function automatic longint div_round_away(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    // Normal = third column of the rotation matrix of the normalised quaternion, held in
    // Q2.30; the dot product and each correction come back to Q16.16 before the subtraction.
    // All intermediate magnitudes stay below 2^63, so plain 64-bit arithmetic is exact.
    function automatic t_projection predict_tangent_projection(input t_quat_force item,
                                                               output int unsigned clipped);
        longint      w, x, y, z;
        longint      norm_sq;
        longint      dot_q16;
        longint      corr;
        longint      diff;
        longint      num[3];
        longint      nrm[3];
        longint      frc[3];
        logic signed [PROJ_W-1:0] lane[3];
        t_projection res;
        int          i;

        w = item.w;
        x = item.x;
        y = item.y;
        z = item.z;
        frc[0] = item.fx;
        frc[1] = item.fy;
        frc[2] = item.fz;

        norm_sq = w * w + x * x + y * y + z * z;
        if (norm_sq == 0) begin
            // zero quaternion: fall back to the z axis
            nrm[0] = 0;
            nrm[1] = 0;
            nrm[2] = Q30_UNIT;
        end else begin
            num[0] = 2 * (x * z + w * y);
            num[1] = 2 * (y * z - w * x);
            num[2] = w * w - x * x - y * y + z * z;
            for (i = 0; i < 3; i++) begin
                nrm[i] = div_round_away(num[i] * Q30_UNIT, norm_sq);
            end
        end

        dot_q16 = div_round_away(nrm[0] * frc[0] + nrm[1] * frc[1] + nrm[2] * frc[2],
                                 Q30_UNIT);

        clipped = 0;
        for (i = 0; i < 3; i++) begin
            corr = div_round_away(nrm[i] * dot_q16, Q30_UNIT);
            diff = frc[i] - corr;
            if (diff > WORD_MAX) begin
                diff = WORD_MAX;
                clipped++;
            end else if (diff < WORD_MIN) begin
                diff = WORD_MIN;
                clipped++;
            end
            lane[i] = PROJ_W'(diff);
        end

        res.px = lane[0];
        res.py = lane[1];
        res.pz = lane[2];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [QUAT_W-1:0] corner_quat();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return 16'sd1;
            4:       return -16'sd1;
            default: return QUAT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [FORCE_W-1:0] corner_force();
        case ($urandom_range(0, 5))
            0:       return F_MAX;
            1:       return F_MIN;
            2:       return '0;
            3:       return 32'sd1;
            4:       return -32'sd1;
            default: return FORCE_W'($urandom);
        endcase
    endfunction

    function automatic t_quat_force make_case(input logic signed [QUAT_W-1:0] w,
                                              input logic signed [QUAT_W-1:0] x,
                                              input logic signed [QUAT_W-1:0] y,
                                              input logic signed [QUAT_W-1:0] z,
                                              input logic signed [FORCE_W-1:0] fx,
                                              input logic signed [FORCE_W-1:0] fy,
                                              input logic signed [FORCE_W-1:0] fz);
        t_quat_force item;
        item.w  = w;
        item.x  = x;
        item.y  = y;
        item.z  = z;
        item.fx = fx;
        item.fy = fy;
        item.fz = fz;
        return item;
    endfunction

    // Random transaction: a mix of full-range, tiny (unnormalised), corner and
    // moderate quaternions, with a similar spread of force magnitudes.
    function automatic t_quat_force random_item();
        t_quat_force item;
        int unsigned qstyle;
        int unsigned fstyle;
        qstyle = $urandom_range(0, 99);
        fstyle = $urandom_range(0, 99);

        if (qstyle < 5) begin
            item.w = '0;
            item.x = '0;
            item.y = '0;
            item.z = '0;
        end else if (qstyle < 45) begin
            item.w = QUAT_W'($urandom);
            item.x = QUAT_W'($urandom);
            item.y = QUAT_W'($urandom);
            item.z = QUAT_W'($urandom);
        end else if (qstyle < 60) begin
            item.w = QUAT_W'(int'($urandom_range(0, 16)) - 8);
            item.x = QUAT_W'(int'($urandom_range(0, 16)) - 8);
            item.y = QUAT_W'(int'($urandom_range(0, 16)) - 8);
            item.z = QUAT_W'(int'($urandom_range(0, 16)) - 8);
        end else if (qstyle < 75) begin
            item.w = corner_quat();
            item.x = corner_quat();
            item.y = corner_quat();
            item.z = corner_quat();
        end else begin
            item.w = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
            item.x = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
            item.y = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
            item.z = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
        end

        if (fstyle < 40) begin
            item.fx = FORCE_W'($urandom);
            item.fy = FORCE_W'($urandom);
            item.fz = FORCE_W'($urandom);
        end else if (fstyle < 70) begin
            item.fx = FORCE_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            item.fy = FORCE_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
            item.fz = FORCE_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        end else if (fstyle < 85) begin
            item.fx = corner_force();
            item.fy = corner_force();
            item.fz = corner_force();
        end else begin
            item.fx = FORCE_W'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
            item.fy = FORCE_W'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
            item.fz = FORCE_W'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
        end
        return item;
    endfunction

    // Offer one request and hold it until accepted; predict its projection at acceptance.
    // Entered and left on a rising edge; valid is left high so a back-to-back request
    // does not drop it within the same step.
    task automatic send_item(input t_quat_force item, input bit allow_gap);
        int unsigned gap;
        int unsigned clipped;
        t_projection predicted;
        gap = (allow_gap && !steady_run) ? pick_gap() : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.quat_w  <= item.w;
        req_if.quat_x  <= item.x;
        req_if.quat_y  <= item.y;
        req_if.quat_z  <= item.z;
        req_if.force_x <= item.fx;
        req_if.force_y <= item.fy;
        req_if.force_z <= item.fz;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);

        predicted = predict_tangent_projection(item, clipped);
        pending_projections.push_back(predicted);
        items_sent++;
        saturated_lanes += clipped;
        if (item.w == 0 && item.x == 0 && item.y == 0 && item.z == 0) begin
            zero_quat_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: identity and its negation, half turns about each axis, the zero quaternion,
    // all-extreme components, scaled copies of one rotation, and a tilted normal that
    // drives a lane past the 32-bit range in both directions.
    task automatic test_directed_cases();
        t_quat_force cases[20];
        int i;
        cases[0]  = make_case(Q_MAX, 0, 0, 0, F_UNIT, 2 * F_UNIT, 3 * F_UNIT);
        cases[1]  = make_case(0, 0, 0, 0, F_MAX, F_MIN, F_MAX);
        cases[2]  = make_case(0, 0, 0, 0, -1, 1, F_MIN);
        cases[3]  = make_case(Q_MIN, Q_MIN, Q_MIN, Q_MIN, F_MAX, F_MAX, F_MAX);
        cases[4]  = make_case(Q_MAX, Q_MAX, Q_MAX, Q_MAX, F_MIN, F_MIN, F_MIN);
        cases[5]  = make_case(Q_MIN, 0, 0, 0, F_UNIT, -F_UNIT, F_UNIT);
        cases[6]  = make_case(0, Q_MAX, 0, 0, 5 * F_UNIT, -7 * F_UNIT, 11 * F_UNIT);
        cases[7]  = make_case(0, 0, Q_MIN, 0, 5 * F_UNIT, -7 * F_UNIT, 11 * F_UNIT);
        cases[8]  = make_case(0, 0, 0, Q_MAX, 5 * F_UNIT, -7 * F_UNIT, 11 * F_UNIT);
        // the same rotation at two scales and both signs
        cases[9]  = make_case(3, 4, 0, 0, F_UNIT, 2 * F_UNIT, -3 * F_UNIT);
        cases[10] = make_case(300, 400, 0, 0, F_UNIT, 2 * F_UNIT, -3 * F_UNIT);
        cases[11] = make_case(-3, -4, 0, 0, F_UNIT, 2 * F_UNIT, -3 * F_UNIT);
        cases[12] = make_case(1, 1, 1, 1, 12345, -54321, 99999);
        cases[13] = make_case(-1, 1, -1, 1, 12345, -54321, 99999);
        // normal close to (1, 1, -1) / sqrt(3): the z lane overshoots the force
        cases[14] = make_case(11994, -16384, 16384, 0, F_MAX, F_MAX, F_MAX);
        cases[15] = make_case(11994, -16384, 16384, 0, F_MIN, F_MIN, F_MIN);
        cases[16] = make_case(-11994, 16384, -16384, 0, F_MAX, F_MAX, F_MAX);
        cases[17] = make_case(Q_MAX, Q_MIN, 0, 0, 0, 0, 0);
        cases[18] = make_case(1, 0, 0, 0, F_MAX, F_MIN, 1);
        cases[19] = make_case(Q_MIN, Q_MAX, Q_MIN, Q_MAX, F_MIN, F_MAX, F_MIN);
        for (i = 0; i < 20; i++) begin
            send_item(cases[i], 1'b1);
        end
    endtask

    // Hold the response side off for a long stretch while requests keep coming,
    // so the pipeline fills and pushes back on its input.
    task automatic test_output_backpressure();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 150; i++) begin
            send_item(random_item(), 1'b0);
        end
    endtask

    // Full rate on both sides: no idle cycles at all.
    task automatic test_gapless_stream();
        int i;
        steady_run = 1'b1;
        for (i = 0; i < 200; i++) begin
            send_item(random_item(), 1'b1);
        end
        steady_run = 1'b0;
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < 1630; i++) begin
            send_item(random_item(), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: ready with random gaps, plus the one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        int unsigned run_left;
        stall_left = 0;
        run_left   = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (run_left != 0) begin
                    run_left--;
                end else if (!steady_run) begin
                    stall_left = pick_gap();
                    run_left   = $urandom_range(0, 15);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each response transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_projection oldest;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            results_checked++;
            if (pending_projections.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected projection (%0d, %0d, %0d), nothing pending",
                             $time, rsp_if.proj_x, rsp_if.proj_y, rsp_if.proj_z);
                end
            end else begin
                oldest = pending_projections.pop_front();
                if (rsp_if.proj_x !== oldest.px || rsp_if.proj_y !== oldest.py ||
                    rsp_if.proj_z !== oldest.pz) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: projection mismatch x exp %0d got %0d, y exp %0d got %0d, z exp %0d got %0d",
                                 $time, oldest.px, rsp_if.proj_x, oldest.py, rsp_if.proj_y,
                                 oldest.pz, rsp_if.proj_z);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long;
    // also count cycles in which the core holds a request off.
    // ------------------------------------------------------------------
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (i_rst_n === 1'b1 && req_if.valid === 1'b1 && req_if.ready !== 1'b1) begin
                input_stall_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles, %0d projections outstanding",
                 WATCHDOG_LIMIT, pending_projections.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.quat_w  <= '0;
        req_if.quat_x  <= '0;
        req_if.quat_y  <= '0;
        req_if.quat_z  <= '0;
        req_if.force_x <= '0;
        req_if.force_y <= '0;
        req_if.force_z <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_gapless_stream();
        test_random_mix();
        req_if.valid <= 1'b0;

        // drain, then give any stray response time to show up
        while (pending_projections.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count += pending_projections.size();

        $display("covered %0d projections: %0d with a zero quaternion, %0d saturated lanes",
                 items_sent, zero_quat_items, saturated_lanes);
        $display("checked %0d responses, %0d request cycles held off, %0d mismatches",
                 results_checked, input_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
